FILE: hw/rtl/date_difference_days_macros.svh
// ----------------------------------------------------------------------------
// date difference assertion macros
// shared property forms for the date difference block
// ----------------------------------------------------------------------------
`ifndef DATE_DIFFERENCE_DAYS_MACROS_SVH
`define DATE_DIFFERENCE_DAYS_MACROS_SVH

// same-cycle implication, quiet during reset
`define DDD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("date difference same-cycle check failed");

// next-cycle implication, quiet during reset
`define DDD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("date difference next-cycle check failed");

`endif

FILE: hw/rtl/ddd_pkg.sv
// ----------------------------------------------------------------------------
// ddd_pkg
// types, constants and calendar tables for the date difference pipeline
// ----------------------------------------------------------------------------
package ddd_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 22;
    localparam int IN_W    = 48;
    localparam int OUT_W   = 24;

    localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // floor(x / 25) = (x * RECIP_25) >> RECIP_SHIFT for x below 4096
    localparam logic [12:0] RECIP_25    = 13'd5243;
    localparam int          RECIP_SHIFT = 17;
    localparam logic [4:0]  DIV_25      = 5'd25;
    localparam logic [8:0]  DAYS_YEAR   = 9'd365;

    // stage 1: decoded date with the reciprocal products
    typedef struct packed {
        logic [DAY_W-1:0]  day;
        logic [1:0]        y_lsb;      // year mod 4
        logic [11:0]       y_quarter;  // year / 4
        logic [24:0]       prod_y;     // (year / 4) * reciprocal of 25
        logic [YEAR_W-1:0] ya;         // year shifted to start in march
        logic [24:0]       prod_a;     // (ya / 4) * reciprocal of 25
        logic [8:0]        offset;     // days from 1 march to month start
        logic [DAY_W-1:0]  base_len;   // month length in a common year
        logic              is_feb;
        logic              range_ok;   // month and year in range
    } date_s1_t;

    // stage 2: validity and the day number in two parts
    typedef struct packed {
        logic [COUNT_W-1:0] partial;   // day number without century terms
        logic [6:0]         century;   // ya/100 - ya/400
        logic               valid;
    } date_s2_t;

    // days from 1 march to the first day of the month
    function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [8:0] r;
        case (m)
            4'd1:    r = 9'd306;
            4'd2:    r = 9'd337;
            4'd3:    r = 9'd0;
            4'd4:    r = 9'd31;
            4'd5:    r = 9'd61;
            4'd6:    r = 9'd92;
            4'd7:    r = 9'd122;
            4'd8:    r = 9'd153;
            4'd9:    r = 9'd184;
            4'd10:   r = 9'd214;
            4'd11:   r = 9'd245;
            4'd12:   r = 9'd275;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // month length in a common year
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] r;
        case (m)
            4'd2:                 r = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
            default:              r = 5'd31;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/date_difference_days.sv
// ----------------------------------------------------------------------------
// date_difference_days
// days between two gregorian dates, four-stage pipeline
//
// usage:
//   s_axis carries one date pair per beat, m_axis one day count per beat.
//   each accepted beat gives exactly one result beat, in order.
//   an accepted beat moves through the stage registers into the output
//   register; a new beat can be accepted every cycle while m_axis is not stalled.
//   the stages are: date decode with reciprocal products, leap year and
//   partial day number, full day number, then compare and subtract into
//   the output register. the constant multiplies by 5243 and by 365 set
//   the depth of the first two stages.
//   the whole pipeline advances together: when m_axis holds a beat that is
//   not taken, every stage holds and s_axis_tready drops, so nothing is lost
//   or repeated. empty stages do not stall, bubbles fill in behind.
//   reset clears every valid bit; payload registers are not reset.
//   an out-of-range day, month or year sets invalid_date with count zero.
//   otherwise count is end minus start when start is earlier, else zero,
//   plus one when include_end is set.
// ----------------------------------------------------------------------------
`include "date_difference_days_macros.svh"
module date_difference_days (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // start_day, start_month, start_year, end_day, end_month, end_year,
    // include_end, one zero pad bit
    input  logic [ddd_pkg::IN_W-1:0] s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // day_count, invalid_date, one zero pad bit
    output logic [ddd_pkg::OUT_W-1:0] m_axis_tdata
);
    import ddd_pkg::*;

    // global advance: the output slot is free or being drained this cycle
    logic advance;

    // input unpack, index 0 is the start date, 1 the end date
    logic [DAY_W-1:0]   in_day   [2];
    logic [MONTH_W-1:0] in_month [2];
    logic [YEAR_W-1:0]  in_year  [2];
    logic               in_inc;

    date_s1_t s1_next [2];
    date_s1_t s1_reg  [2];
    date_s2_t s2_next [2];
    date_s2_t s2_reg  [2];
    logic [COUNT_W-1:0] dn_next [2];
    logic [COUNT_W-1:0] dn_reg  [2];

    logic v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic inc1_reg, inc2_reg, inc3_reg;
    logic ok3_next, ok3_reg;

    logic [COUNT_W-1:0] count_next, count_reg;
    logic               invalid_next, invalid_reg;

    assign in_day[0]   = s_axis_tdata[4:0];
    assign in_month[0] = s_axis_tdata[8:5];
    assign in_year[0]  = s_axis_tdata[22:9];
    assign in_day[1]   = s_axis_tdata[27:23];
    assign in_month[1] = s_axis_tdata[31:28];
    assign in_year[1]  = s_axis_tdata[45:32];
    assign in_inc      = s_axis_tdata[46];

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;

    // ------------------------------------------------------------------
    // per-date stages 1 to 3
    // ------------------------------------------------------------------
    for (genvar i = 0; i < 2; i++) begin : g_date
        logic [YEAR_W-1:0] ya;
        logic [6:0]        q_y;
        logic [11:0]       rem_y;
        logic              leap;
        logic [DAY_W-1:0]  len;
        logic [6:0]        q_a;
        logic [11:0]       ya_quarter;

        // stage 1: march-based year, month tables, reciprocal products
        always_comb
        begin
            ya = (in_month[i] <= MONTH_FEB) ? in_year[i] - YEAR_MIN : in_year[i];
            s1_next[i].day       = in_day[i];
            s1_next[i].y_lsb     = in_year[i][1:0];
            s1_next[i].y_quarter = in_year[i][YEAR_W-1:2];
            s1_next[i].prod_y    = 25'(in_year[i][YEAR_W-1:2]) * 25'(RECIP_25);
            s1_next[i].ya        = ya;
            s1_next[i].prod_a    = 25'(ya[YEAR_W-1:2]) * 25'(RECIP_25);
            s1_next[i].offset    = month_offset(in_month[i]);
            s1_next[i].base_len  = month_len(in_month[i]);
            s1_next[i].is_feb    = (in_month[i] == MONTH_FEB);
            s1_next[i].range_ok  = (in_month[i] != '0) && (in_month[i] <= MONTH_DEC)
                                   && (in_year[i] >= YEAR_MIN) && (in_year[i] <= YEAR_MAX);
        end

        // stage 2: leap rule, day check, day number without century terms
        always_comb
        begin
            q_y   = s1_reg[i].prod_y[RECIP_SHIFT+6:RECIP_SHIFT];
            rem_y = s1_reg[i].y_quarter - 12'(q_y) * 12'(DIV_25);
            // divisible by 4, and not a century unless also by 400
            leap  = (s1_reg[i].y_lsb == 2'd0) && ((rem_y != '0) || (q_y[1:0] == 2'd0));
            len   = s1_reg[i].base_len + DAY_W'(s1_reg[i].is_feb && leap);
            q_a   = s1_reg[i].prod_a[RECIP_SHIFT+6:RECIP_SHIFT];
            ya_quarter = s1_reg[i].ya[YEAR_W-1:2];
            s2_next[i].valid   = s1_reg[i].range_ok && (s1_reg[i].day != '0)
                                 && (s1_reg[i].day <= len);
            s2_next[i].partial = COUNT_W'(s1_reg[i].ya) * COUNT_W'(DAYS_YEAR)
                                 + COUNT_W'(ya_quarter) + COUNT_W'(s1_reg[i].offset)
                                 + COUNT_W'(s1_reg[i].day) - COUNT_W'(1);
            s2_next[i].century = q_a - {2'b00, q_a[6:2]};
        end

        // stage 3: full day number
        assign dn_next[i] = s2_reg[i].partial - COUNT_W'(s2_reg[i].century);

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                s1_reg[i] <= s1_next[i];
                s2_reg[i] <= s2_next[i];
                dn_reg[i] <= dn_next[i];
            end
        end
    end

    assign ok3_next = s2_reg[0].valid && s2_reg[1].valid;

    // stage 4: compare, subtract and add the end day
    always_comb
    begin
        count_next   = '0;
        invalid_next = !ok3_reg;
        if (ok3_reg)
        begin
            if (dn_reg[0] < dn_reg[1])
            begin
                count_next = dn_reg[1] - dn_reg[0];
            end
            count_next = count_next + COUNT_W'(inc3_reg);
        end
    end

    // payload side registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            inc1_reg    <= in_inc;
            inc2_reg    <= inc1_reg;
            inc3_reg    <= inc2_reg;
            ok3_reg     <= ok3_next;
            count_reg   <= count_next;
            invalid_reg <= invalid_next;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg        <= s_axis_tvalid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, invalid_reg, count_reg};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // an accepted beat always lands in the first stage
    `DDD_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, v1_reg)
    // the last stage moves into the output register when the pipe advances
    `DDD_ASSERT_NEXT(a_stage_to_out, v3_reg && advance, m_axis_tvalid)
    // an invalid date never carries a count
    `DDD_ASSERT_SAME(a_invalid_zero, m_axis_tvalid && m_axis_tdata[22],
        m_axis_tdata[21:0] == '0)

endmodule

FILE: tb/sv/date_difference_days_tb.sv
// ----------------------------------------------------------------------------
// date_difference_days_tb
// self-checking bench for the gregorian date difference pipeline
//
// date pairs are queued by an initial block: a short directed set of
// calendar corner cases, then random pairs that are mostly well-formed
// dates with random content, some near each other, some with a bad day and
// some raw noise. a clocked driver sends them with random gaps and a
// clocked monitor takes results with random stalls. every accepted pair is
// run through a local calendar predictor and the results are compared field
// by field, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module date_difference_days_tb;

    import ddd_pkg::*;

    localparam int RANDOM_PAIRS = 1100;
    localparam int IDLE_LIMIT   = 2000;  // cycles with no beat on either side
    localparam int TAIL_CYCLES  = 12;    // pipeline is four deep

    // one calendar date, day in the lowest bits
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } calendar_date_t;

    // one input beat, start date in the lowest bits
    typedef struct packed {
        logic           include_end;
        calendar_date_t end_date;
        calendar_date_t start_date;
    } date_pair_t;

    // one result beat, day count in the lowest bits
    typedef struct packed {
        logic               invalid_date;
        logic [COUNT_W-1:0] day_count;
    } day_span_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;

    date_pair_t  pending_pairs[$];   // pairs waiting to be sent
    day_span_t   expected_spans[$];  // predictions for accepted pairs, oldest first

    int  mismatches     = 0;
    int  pairs_accepted = 0;
    int  spans_checked  = 0;
    int  invalid_seen   = 0;
    int  long_spans     = 0;
    int  idle_cycles    = 0;
    int  send_gap       = 0;
    int  send_calm      = 0;
    int  stall_left     = 0;
    int  stall_calm     = 0;
    bit  timed_out      = 1'b0;

    day_span_t  got_span;
    day_span_t  want_span;

    always #5 clk = ~clk;

    date_difference_days dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------------
    // calendar predictor
    // ------------------------------------------------------------------------

    function automatic bit leap(input logic [YEAR_W-1:0] y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    // length of month m (1 to 12) in year y
    function automatic int unsigned days_in(input logic [MONTH_W-1:0] m,
                                            input logic [YEAR_W-1:0] y);
        if (m == MONTH_FEB)
            return leap(y) ? 29 : 28;
        if (m inside {4'd4, 4'd6, 4'd9, 4'd11})
            return 30;
        return 31;
    endfunction

    function automatic bit well_formed(input calendar_date_t dt);
        if (dt.month < 1 || dt.month > MONTH_DEC)
            return 1'b0;
        if (dt.year < YEAR_MIN || dt.year > YEAR_MAX)
            return 1'b0;
        return dt.day >= 1 && dt.day <= days_in(dt.month, dt.year);
    endfunction

    // days since 1 march of year 0, years taken to start in march
    function automatic int unsigned march_day_index(input calendar_date_t dt);
        int unsigned ya;
        int unsigned shifted_month;
        ya            = (dt.month <= MONTH_FEB) ? dt.year - 1 : dt.year;
        shifted_month = (dt.month + 9) % 12;
        return 365 * ya + ya / 4 - ya / 100 + ya / 400
               + (153 * shifted_month + 2) / 5 + dt.day - 1;
    endfunction

    function automatic day_span_t span_of(input date_pair_t p);
        day_span_t   r;
        int unsigned a;
        int unsigned b;
        r = '0;
        if (!well_formed(p.start_date) || !well_formed(p.end_date))
        begin
            r.invalid_date = 1'b1;
        end
        else
        begin
            a           = march_day_index(p.start_date);
            b           = march_day_index(p.end_date);
            // include_end counts even when start is not before end
            r.day_count = COUNT_W'(((a < b) ? b - a : 0) + p.include_end);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic date_pair_t pair_of(input int sd, input int sm, input int sy,
                                           input int ed, input int em, input int ey,
                                           input int inc);
        date_pair_t p;
        p.start_date.day   = DAY_W'(sd);
        p.start_date.month = MONTH_W'(sm);
        p.start_date.year  = YEAR_W'(sy);
        p.end_date.day     = DAY_W'(ed);
        p.end_date.month   = MONTH_W'(em);
        p.end_date.year    = YEAR_W'(ey);
        p.include_end      = 1'(inc);
        return p;
    endfunction

    // mostly uniform, otherwise a range edge or a year where the leap rule turns
    function automatic int unsigned pick_year();
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(YEAR_MIN, YEAR_MAX);
        case ($urandom_range(0, 9))
            0:       return 1;
            1:       return 4;
            2:       return 1600;
            3:       return 1700;
            4:       return 1900;
            5:       return 2000;
            6:       return 2100;
            7:       return 2400;
            8:       return 9996;
            default: return YEAR_MAX;
        endcase
    endfunction

    // a valid date in year y, month ends favoured
    function automatic calendar_date_t pick_date(input int unsigned y);
        calendar_date_t dt;
        int unsigned    len;
        dt.year  = YEAR_W'(y);
        dt.month = MONTH_W'($urandom_range(1, MONTH_DEC));
        len      = days_in(dt.month, dt.year);
        case ($urandom_range(0, 7))
            0:       dt.day = DAY_W'(len);
            1:       dt.day = 5'd1;
            default: dt.day = DAY_W'($urandom_range(1, len));
        endcase
        return dt;
    endfunction

    function automatic date_pair_t random_pair();
        date_pair_t  p;
        logic [63:0] raw;
        int unsigned mode;
        int unsigned y;
        mode = $urandom_range(0, 99);
        if (mode >= 92)
        begin
            // raw noise over the whole field range
            raw = {$urandom, $urandom};
            p   = raw[46:0];
            return p;
        end
        y            = pick_year();
        p.start_date = pick_date(y);
        if (mode < 55)
        begin
            p.end_date = pick_date(pick_year());
        end
        else
        begin
            // nearby end date, same or following year
            y = y + $urandom_range(0, 1);
            if (y > YEAR_MAX)
                y = YEAR_MAX;
            p.end_date = pick_date(y);
        end
        if (mode >= 82)
        begin
            // one day field broken: zero or past the month end
            if ($urandom_range(0, 1))
                p.start_date.day = DAY_W'($urandom_range(0, 3) == 0 ? 0 :
                    $urandom_range(days_in(p.start_date.month, p.start_date.year) + 1, 31));
            else
                p.end_date.day = DAY_W'($urandom_range(0, 3) == 0 ? 0 :
                    $urandom_range(days_in(p.end_date.month, p.end_date.year) + 1, 31));
        end
        p.include_end = 1'($urandom_range(0, 1));
        return p;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got_v,
                                   input int unsigned want_v);
        $display("mismatch at %0t: %s got %0d want %0d", $time, what, got_v, want_v);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // driver: one date pair per beat from the pending queue
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            // beat taken at this edge, predict its result
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_spans.push_back(span_of(date_pair_t'(s_axis_tdata[46:0])));
                pairs_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_pairs.size() > 0)
                begin
                    s_axis_tdata  <= {1'b0, pending_pairs.pop_front()};
                    s_axis_tvalid <= 1'b1;
                    // occasional stretch of back-to-back beats
                    if (send_calm > 0)
                    begin
                        send_calm--;
                        send_gap = 0;
                    end
                    else
                    begin
                        send_gap = idle_length();
                        if ($urandom_range(0, 59) == 0)
                            send_calm = $urandom_range(20, 80);
                    end
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: random back-pressure and in-order comparison
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_span = m_axis_tdata[22:0];
                if (expected_spans.size() == 0)
                begin
                    report_mismatch("result beat with nothing expected, day_count",
                                    32'(got_span.day_count), 0);
                end
                else
                begin
                    want_span = expected_spans.pop_front();
                    if (got_span.day_count !== want_span.day_count)
                        report_mismatch("day_count", 32'(got_span.day_count),
                                        32'(want_span.day_count));
                    if (got_span.invalid_date !== want_span.invalid_date)
                        report_mismatch("invalid_date", 32'(got_span.invalid_date),
                                        32'(want_span.invalid_date));
                    spans_checked++;
                    if (want_span.invalid_date)
                        invalid_seen++;
                    if (want_span.day_count > 366)
                        long_spans++;
                end
            end
            // back-pressure pattern, with calm stretches of constant ready
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_calm > 0)
            begin
                stall_calm--;
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = idle_length();
                else if ($urandom_range(0, 99) == 0)
                    stall_calm = $urandom_range(30, 100);
            end
        end
    end

    // watchdog: cycles in which no beat moves on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        // widest span, with and without the end day
        pending_pairs.push_back(pair_of(1, 1, 1, 31, 12, 9999, 1));
        pending_pairs.push_back(pair_of(1, 1, 1, 31, 12, 9999, 0));
        // same date, and start after end, both flag values
        pending_pairs.push_back(pair_of(15, 6, 2024, 15, 6, 2024, 0));
        pending_pairs.push_back(pair_of(15, 6, 2024, 15, 6, 2024, 1));
        pending_pairs.push_back(pair_of(2, 6, 2024, 1, 6, 2024, 1));
        pending_pairs.push_back(pair_of(31, 12, 9999, 1, 1, 1, 0));
        // leap rule: divisible by 400, by 4, century skipped
        pending_pairs.push_back(pair_of(29, 2, 2000, 1, 3, 2000, 0));
        pending_pairs.push_back(pair_of(29, 2, 2024, 1, 1, 2025, 1));
        pending_pairs.push_back(pair_of(28, 2, 2100, 1, 3, 2100, 0));
        pending_pairs.push_back(pair_of(28, 2, 1600, 1, 3, 1600, 0));
        pending_pairs.push_back(pair_of(31, 12, 1999, 1, 1, 2000, 0));
        pending_pairs.push_back(pair_of(1, 1, 1, 1, 3, 1, 0));
        // invalid day: feb 29 in common years, zero, past month end
        pending_pairs.push_back(pair_of(29, 2, 1900, 1, 3, 1900, 1));
        pending_pairs.push_back(pair_of(1, 1, 2023, 29, 2, 2023, 0));
        pending_pairs.push_back(pair_of(0, 5, 2010, 3, 5, 2010, 1));
        pending_pairs.push_back(pair_of(1, 4, 2010, 31, 4, 2010, 0));
        pending_pairs.push_back(pair_of(31, 2, 2012, 1, 3, 2012, 1));
        // month out of range
        pending_pairs.push_back(pair_of(1, 0, 2010, 1, 1, 2011, 1));
        pending_pairs.push_back(pair_of(1, 13, 2010, 1, 1, 2011, 0));
        pending_pairs.push_back(pair_of(1, 1, 2010, 1, 15, 2011, 1));
        // year out of range
        pending_pairs.push_back(pair_of(1, 1, 0, 1, 1, 2011, 1));
        pending_pairs.push_back(pair_of(1, 1, 2010, 1, 1, 10000, 0));
        // every field all ones, then all zeros
        pending_pairs.push_back(pair_of(31, 15, 16383, 31, 15, 16383, 1));
        pending_pairs.push_back(pair_of(0, 0, 0, 0, 0, 0, 0));

        for (int i = 0; i < RANDOM_PAIRS; i++)
            pending_pairs.push_back(random_pair());

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (!timed_out && !(pending_pairs.size() == 0 && !s_axis_tvalid
                               && expected_spans.size() == 0))
        begin
            @(posedge clk);
            if (idle_cycles >= IDLE_LIMIT)
                timed_out = 1'b1;
        end
        // anything arriving now is an extra result, the monitor flags it
        if (!timed_out)
            repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d date pairs, %0d results checked", pairs_accepted,
                 spans_checked);
        $display("%0d flagged invalid, %0d spans over a year, %0d errors",
                 invalid_seen, long_spans, mismatches);
        if (timed_out)
        begin
            $display("watchdog expired with %0d results outstanding",
                     expected_spans.size());
            $display("end of test: mismatches");
        end
        else if (mismatches == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
